>>> sv/ddd_pkg.sv
// Shared types, codes and date helper functions for the date difference block.
package ddd_pkg;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_FIRST_BAD  = 2'd1,
    STATUS_SECOND_BAD = 2'd2
  } status_e;

  // Year offset from 1951; the accepted window is 1951 to 2050.
  localparam int unsigned YearIdxW = 7;
  localparam int unsigned OrdW     = 16;

  typedef struct packed {
    logic [4:0]  first_day;
    logic [3:0]  first_month;
    logic [13:0] first_year;
    logic [4:0]  second_day;
    logic [3:0]  second_month;
    logic [13:0] second_year;
  } in_item_t;

  typedef struct packed {
    logic [15:0] elapsed_days;
    logic [1:0]  status;
  } out_item_t;

  // One checked date, held between classification and ordinal math.
  typedef struct packed {
    logic [YearIdxW-1:0] yidx;
    logic                leap;
    logic [3:0]          month;
    logic [4:0]          day;
  } date_info_t;

  typedef struct packed {
    status_e    status;
    date_info_t a;
    date_info_t b;
  } front_t;

  // Queue entry: status and both day ordinals.
  typedef struct packed {
    status_e         status;
    logic [OrdW-1:0] ord_a;
    logic [OrdW-1:0] ord_b;
  } qentry_t;

  typedef struct packed {
    logic ok;
    logic [YearIdxW-1:0] yidx;
  } year_t;

  // Raw year to offset from 1951.
  function automatic year_t norm_year(input logic [13:0] raw);
    year_t r;
    r.ok   = 1'b1;
    r.yidx = '0;
    if (raw <= 14'd50) begin
      r.yidx = YearIdxW'(raw + 14'd49);
    end else if (raw <= 14'd99) begin
      r.yidx = YearIdxW'(raw - 14'd51);
    end else if (raw >= 14'd1951 && raw <= 14'd2050) begin
      r.yidx = YearIdxW'(raw - 14'd1951);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // Within 1951..2050 a year is leap exactly when it is a multiple of 4.
  function automatic logic is_leap(input logic [YearIdxW-1:0] yidx);
    return yidx[1:0] == 2'd1;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before_month(input logic [3:0] month);
    logic [8:0] d;
    case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  function automatic logic date_ok(input logic [4:0] day, input logic [3:0] month,
                                   input year_t y);
    logic leap;
    leap = is_leap(y.yidx);
    return y.ok && (month inside {[4'd1:4'd12]}) && (day != 5'd0) &&
           (day <= month_len(month, leap));
  endfunction

  // Days since 1951-01-01 plus one; only differences matter.
  function automatic logic [OrdW-1:0] ordinal(input date_info_t di);
    logic [OrdW-1:0] yr_days;
    logic [7:0]      leaps;
    logic [OrdW-1:0] extra;
    yr_days = OrdW'(di.yidx) * OrdW'(365);
    leaps   = ({1'b0, di.yidx} + 8'd2) >> 2;
    extra   = (di.leap && di.month > 4'd2) ? OrdW'(1) : OrdW'(0);
    return yr_days + OrdW'(leaps) + OrdW'(days_before_month(di.month)) +
           OrdW'(di.day) + extra;
  endfunction

endpackage

>>> sv/ddd_front.sv
// Front end: accepts date pairs, classifies them and forms day ordinals.
module ddd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ddd_pkg::in_item_t in_item_i,
  output logic              push_o,
  input  logic              q_full_i,
  output ddd_pkg::qentry_t  push_data_o
);

  logic            valid_q, valid_d;
  ddd_pkg::front_t item_q, item_d;
  ddd_pkg::year_t  ya, yb;
  logic            ok_a, ok_b, load;

  assign in_stall_o = valid_q & q_full_i;
  assign push_o     = valid_q & ~q_full_i;
  assign load       = in_valid_i & ~in_stall_o;

  always_comb begin
    ya   = ddd_pkg::norm_year(in_item_i.first_year);
    yb   = ddd_pkg::norm_year(in_item_i.second_year);
    ok_a = ddd_pkg::date_ok(in_item_i.first_day, in_item_i.first_month, ya);
    ok_b = ddd_pkg::date_ok(in_item_i.second_day, in_item_i.second_month, yb);

    item_d.a.yidx  = ya.yidx;
    item_d.a.leap  = ddd_pkg::is_leap(ya.yidx);
    item_d.a.month = in_item_i.first_month;
    item_d.a.day   = in_item_i.first_day;
    item_d.b.yidx  = yb.yidx;
    item_d.b.leap  = ddd_pkg::is_leap(yb.yidx);
    item_d.b.month = in_item_i.second_month;
    item_d.b.day   = in_item_i.second_day;
    if (!ok_a) begin
      item_d.status = ddd_pkg::STATUS_FIRST_BAD;
    end else if (!ok_b) begin
      item_d.status = ddd_pkg::STATUS_SECOND_BAD;
    end else begin
      item_d.status = ddd_pkg::STATUS_OK;
    end

    valid_d = load | (valid_q & ~push_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

  always_comb begin
    push_data_o.status = item_q.status;
    push_data_o.ord_a  = ddd_pkg::ordinal(item_q.a);
    push_data_o.ord_b  = ddd_pkg::ordinal(item_q.b);
  end

endmodule

>>> sv/ddd_queue.sv
// Two-entry queue between the front end and the back end.
module ddd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ddd_pkg::qentry_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output ddd_pkg::qentry_t pop_data_o
);

  ddd_pkg::qentry_t entry_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  assign full_o     = count_q == 2'd2;
  assign empty_o    = count_q == 2'd0;
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> sv/ddd_back.sv
// Back end: absolute ordinal difference into the output register.
module ddd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  ddd_pkg::qentry_t   q_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ddd_pkg::out_item_t out_item_o
);

  logic               valid_q, valid_d;
  ddd_pkg::out_item_t item_q, item_d;
  logic [15:0]        diff;

  assign pop_o = ~q_empty_i & (~valid_q | ~out_stall_i);

  always_comb begin
    diff = (q_data_i.ord_a >= q_data_i.ord_b) ? q_data_i.ord_a - q_data_i.ord_b
                                              : q_data_i.ord_b - q_data_i.ord_a;
    item_d.status       = q_data_i.status;
    item_d.elapsed_days = (q_data_i.status == ddd_pkg::STATUS_OK) ? diff : 16'd0;
    valid_d             = pop_o | (valid_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

>>> sv/date_difference_days.sv
// Top level of the date difference block: front end, queue and back end.
//
// Input channel: in_valid_i / in_stall_o carry one date pair per transfer
// (day, month and raw year of two dates). Raw years 0-50 map to 2000+y,
// 51-99 to 1900+y, 1951-2050 stand as they are; anything else is invalid.
// Output channel: out_valid_o / out_stall_i carry one result per input
// transfer: the absolute number of days between the dates and a status
// (ok, first date invalid, second date invalid). Days read zero unless ok.
// Path: an accepted pair loads the classify register, moves from there into
// the queue and from the queue into the output register, whose valid flag
// drives out_valid_o.
// Throughput: one pair per cycle while no stall holds the flow. A full queue
// does not take a push in the cycle it pops, even with a waiting item.
// When the receiver stalls, the output register holds its result, the queue
// fills, and then in_stall_o rises while the front end holds its item.
// Reset (rst_ni low, asynchronous) empties every stage and the queue; no
// results are pending afterwards. There is no configuration.
module date_difference_days (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ddd_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ddd_pkg::out_item_t out_item_o
);

  logic             push, q_full, pop, q_empty;
  ddd_pkg::qentry_t push_data, pop_data;

  // Range checks, leap year and day ordinals.
  ddd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .push_o      (push),
    .q_full_i    (q_full),
    .push_data_o (push_data)
  );

  // Decouples front-end progress from output stalls.
  ddd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_data_o  (pop_data)
  );

  // Absolute difference and result register.
  ddd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
